// ===== rtl/mmed_pkg.sv =====
package mmed_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int FILL_W     = 16;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUCKET_SIZE = 1'b0,
        CFG_PASSTHROUGH = 1'b1
    } t_cfg_reg;

    // results pushed by one request: first point, second point
    typedef struct packed {
        logic a_valid;
        logic b_valid;
    } t_push;

endpackage

// ===== rtl/mmed_core.sv =====
module mmed_core #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_fire,
    input  logic signed [DATA_WIDTH-1:0]       i_time,
    input  logic signed [DATA_WIDTH-1:0]       i_value,
    input  logic                               i_finite,
    input  logic                               i_last,
    input  logic [mmed_pkg::FILL_W-1:0]        i_bucket_size,
    input  logic                               i_passthrough,
    output mmed_pkg::t_push                    o_push,
    output logic signed [DATA_WIDTH-1:0]       o_a_time,
    output logic signed [DATA_WIDTH-1:0]       o_a_value,
    output logic signed [DATA_WIDTH-1:0]       o_b_time,
    output logic signed [DATA_WIDTH-1:0]       o_b_value
);
    import mmed_pkg::*;

    logic [FILL_W-1:0]            r_fill, n_fill;
    logic                         r_has, n_has;
    logic signed [DATA_WIDTH-1:0] r_lo_v, r_lo_t, r_hi_v, r_hi_t;
    logic signed [DATA_WIDTH-1:0] n_lo_v, n_lo_t, n_hi_v, n_hi_t;
    logic [FILL_W-1:0]            r_lo_pos, r_hi_pos, n_lo_pos, n_hi_pos;
    logic signed [DATA_WIDTH-1:0] r_prev_t, r_prev_v, n_prev_t, n_prev_v;
    logic                         r_prev_valid, n_prev_valid;

    logic [FILL_W-1:0]            size_eff;
    logic [FILL_W-1:0]            fill_inc;
    logic                         has_next;
    logic                         flush;
    logic                         same_pos;
    logic                         lo_first;
    logic signed [DATA_WIDTH-1:0] a_t, a_v, b_t, b_v;
    logic                         a_dup;
    logic                         emit_a, emit_b;

    always_comb begin
        size_eff = (i_bucket_size == '0) ? FILL_W'(1) : i_bucket_size;
        fill_inc = r_fill + FILL_W'(1);

        n_lo_v   = r_lo_v;
        n_lo_t   = r_lo_t;
        n_lo_pos = r_lo_pos;
        n_hi_v   = r_hi_v;
        n_hi_t   = r_hi_t;
        n_hi_pos = r_hi_pos;
        if (i_finite) begin
            if (!r_has) begin
                n_lo_v   = i_value;
                n_lo_t   = i_time;
                n_lo_pos = r_fill;
                n_hi_v   = i_value;
                n_hi_t   = i_time;
                n_hi_pos = r_fill;
            end else begin
                // strict compares keep the first occurrence on ties
                if (i_value < r_lo_v) begin
                    n_lo_v   = i_value;
                    n_lo_t   = i_time;
                    n_lo_pos = r_fill;
                end
                if (r_hi_v < i_value) begin
                    n_hi_v   = i_value;
                    n_hi_t   = i_time;
                    n_hi_pos = r_fill;
                end
            end
        end
        has_next = r_has | i_finite;
        flush    = (fill_inc >= size_eff) || (fill_inc == '0) || i_last;

        same_pos = (n_lo_pos == n_hi_pos);
        lo_first = (n_lo_pos < n_hi_pos);
        a_t = (lo_first || same_pos) ? n_lo_t : n_hi_t;
        a_v = (lo_first || same_pos) ? n_lo_v : n_hi_v;
        b_t = lo_first ? n_hi_t : n_lo_t;
        b_v = lo_first ? n_hi_v : n_lo_v;

        // a dropped first point equals the history, so the second point
        // only has to differ from the first one
        a_dup  = r_prev_valid && (r_prev_t == a_t) && (r_prev_v == a_v);
        emit_a = flush && has_next && !a_dup;
        emit_b = flush && has_next && !same_pos && !((b_t == a_t) && (b_v == a_v));

        n_prev_t     = r_prev_t;
        n_prev_v     = r_prev_v;
        n_prev_valid = r_prev_valid;
        n_fill       = fill_inc;
        n_has        = has_next;

        if (i_passthrough) begin
            n_fill = r_fill;
            n_has  = r_has;
            if (i_last) begin
                n_fill       = '0;
                n_has        = 1'b0;
                n_prev_valid = 1'b0;
            end
            o_push.a_valid = 1'b1;
            o_push.b_valid = 1'b0;
            o_a_time       = i_time;
            o_a_value      = i_value;
        end else begin
            if (emit_b) begin
                n_prev_t     = b_t;
                n_prev_v     = b_v;
                n_prev_valid = 1'b1;
            end else if (emit_a) begin
                n_prev_t     = a_t;
                n_prev_v     = a_v;
                n_prev_valid = 1'b1;
            end
            if (flush) begin
                n_fill = '0;
                n_has  = 1'b0;
                if (i_last) begin
                    n_prev_valid = 1'b0;
                end
            end
            o_push.a_valid = emit_a;
            o_push.b_valid = emit_b;
            o_a_time       = a_t;
            o_a_value      = a_v;
        end
        o_b_time  = b_t;
        o_b_value = b_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_has        <= 1'b0;
            r_prev_valid <= 1'b0;
        end else if (i_fire) begin
            r_fill       <= n_fill;
            r_has        <= n_has;
            r_prev_valid <= n_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && !i_passthrough) begin
            r_lo_v   <= n_lo_v;
            r_lo_t   <= n_lo_t;
            r_lo_pos <= n_lo_pos;
            r_hi_v   <= n_hi_v;
            r_hi_t   <= n_hi_t;
            r_hi_pos <= n_hi_pos;
            r_prev_t <= n_prev_t;
            r_prev_v <= n_prev_v;
        end
    end

endmodule

// ===== rtl/mmed_out_fifo.sv =====
module mmed_out_fifo #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mmed_pkg::t_push               i_push,
    input  logic signed [DATA_WIDTH-1:0]  i_a_time,
    input  logic signed [DATA_WIDTH-1:0]  i_a_value,
    input  logic signed [DATA_WIDTH-1:0]  i_b_time,
    input  logic signed [DATA_WIDTH-1:0]  i_b_value,
    output logic                          o_room,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [DATA_WIDTH-1:0]  o_time,
    output logic signed [DATA_WIDTH-1:0]  o_value,
    output logic                          o_run_end
);
    import mmed_pkg::*;

    logic signed [DATA_WIDTH-1:0] r_time  [FIFO_DEPTH];
    logic signed [DATA_WIDTH-1:0] r_value [FIFO_DEPTH];
    logic                         r_end   [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]        r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0]        r_count, n_count;
    logic [FIFO_PTR_W-1:0]        wr_b;
    logic                         pop;

    assign o_room    = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign o_valid   = (r_count != '0);
    assign o_time    = r_time[r_rd_ptr];
    assign o_value   = r_value[r_rd_ptr];
    assign o_run_end = r_end[r_rd_ptr];
    assign pop       = o_valid && !i_stall;
    assign wr_b      = r_wr_ptr + FIFO_PTR_W'(i_push.a_valid);

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(i_push.a_valid) + FIFO_PTR_W'(i_push.b_valid);
        n_rd_ptr = r_rd_ptr + FIFO_PTR_W'(pop);
        n_count  = r_count + FIFO_CNT_W'(i_push.a_valid) + FIFO_CNT_W'(i_push.b_valid)
                 - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_time[r_wr_ptr]  <= i_a_time;
            r_value[r_wr_ptr] <= i_a_value;
            r_end[r_wr_ptr]   <= !i_push.b_valid;
        end
        if (i_push.b_valid) begin
            r_time[wr_b]  <= i_b_time;
            r_value[wr_b] <= i_b_value;
            r_end[wr_b]   <= 1'b1;
        end
    end

endmodule

// ===== rtl/min_max_envelope_decimator_top.sv =====
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-----------------------------------------------
// input    | i_in_valid / o_in_stall   | i_sample_time, i_sample_value, i_sample_finite,
//          |                           | i_trace_last
// output   | o_out_valid / i_out_stall | o_out_time, o_out_value, o_run_end
// config   | i_cfg_wr_en               | i_cfg_index, i_cfg_data
//
// One request per cycle while o_in_stall is low: a request waits in the input register,
// then its zero to two points go into a four-entry output queue, and the first point
// is driven to the output from the queue's head entry, where it can then be taken.
// The output side sets the sustained rate: one point per cycle while i_out_stall is low.
// o_in_stall rises only while the input register is full and the queue cannot take
// two more points. Reset is synchronous and clears the bucket, history and queue.
module min_max_envelope_decimator_top #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [DATA_WIDTH-1:0]         i_sample_time,
    input  logic signed [DATA_WIDTH-1:0]         i_sample_value,
    input  logic                                 i_sample_finite,
    input  logic                                 i_trace_last,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [DATA_WIDTH-1:0]         o_out_time,
    output logic signed [DATA_WIDTH-1:0]         o_out_value,
    output logic                                 o_run_end,
    input  logic                                 i_cfg_wr_en,
    input  logic [mmed_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mmed_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mmed_pkg::*;

    logic [FILL_W-1:0]            r_bucket_size;
    logic                         r_passthrough;

    logic                         r_s1_valid, n_s1_valid;
    logic signed [DATA_WIDTH-1:0] r_s1_time, r_s1_value;
    logic                         r_s1_finite, r_s1_last;

    logic                         fifo_room;
    logic                         s1_fire;
    logic                         in_accept;
    t_push                        push;
    logic signed [DATA_WIDTH-1:0] a_time, a_value, b_time, b_value;

    assign s1_fire    = r_s1_valid && fifo_room;
    assign o_in_stall = r_s1_valid && !fifo_room;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_fire) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_bucket_size <= FILL_W'(1);
            r_passthrough <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (i_cfg_wr_en) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_BUCKET_SIZE: begin
                        r_bucket_size <= i_cfg_data;
                    end
                    CFG_PASSTHROUGH: begin
                        r_passthrough <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_time   <= i_sample_time;
            r_s1_value  <= i_sample_value;
            r_s1_finite <= i_sample_finite;
            r_s1_last   <= i_trace_last;
        end
    end

    mmed_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (s1_fire),
        .i_time        (r_s1_time),
        .i_value       (r_s1_value),
        .i_finite      (r_s1_finite),
        .i_last        (r_s1_last),
        .i_bucket_size (r_bucket_size),
        .i_passthrough (r_passthrough),
        .o_push        (push),
        .o_a_time      (a_time),
        .o_a_value     (a_value),
        .o_b_time      (b_time),
        .o_b_value     (b_value)
    );

    t_push push_gated;
    assign push_gated.a_valid = push.a_valid && s1_fire;
    assign push_gated.b_valid = push.b_valid && s1_fire;

    mmed_out_fifo #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push_gated),
        .i_a_time  (a_time),
        .i_a_value (a_value),
        .i_b_time  (b_time),
        .i_b_value (b_value),
        .o_room    (fifo_room),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_time    (o_out_time),
        .o_value   (o_out_value),
        .o_run_end (o_run_end)
    );

endmodule

// ===== rtl/mmed_checker.sv =====
module mmed_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [DATA_WIDTH-1:0]         o_out_time,
    input logic signed [DATA_WIDTH-1:0]         o_out_value,
    input logic                                 o_run_end
);

    // the queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // a stalled output point holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_time) && $stable(o_out_value)
            && $stable(o_run_end))
        else $error("stalled output point changed");

    // with nothing waiting at the output, input is never held off
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while output queue empty");

    // the second point of a request follows at once and differs from the first
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_run_end |=>
            o_out_valid && (o_out_time != $past(o_out_time)
            || o_out_value != $past(o_out_value)))
        else $error("second point missing or repeats the first");

endmodule

bind min_max_envelope_decimator_top mmed_checker #(.DATA_WIDTH(DATA_WIDTH)) u_mmed_checker (.*);
